// ===== hw/rtl/bhm_pkg.sv =====
// Shared types and constants for the byte histogram mode finder.
`timescale 1ns / 1ps

package bhm_pkg;

    // Width of one histogram count
    localparam int COUNT_BITS = 16;
    localparam int NUM_VALUES = 256;
    localparam int VALUE_BITS = $clog2(NUM_VALUES);

    typedef logic [VALUE_BITS-1:0] t_byte;
    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_count COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam t_byte  ZERO_BYTE = '0;

    // One request moving out of the input stage into the count update
    typedef struct packed {
        logic  fire;
        t_byte value;
        logic  last;
    } t_step;

endpackage : bhm_pkg

// ===== hw/rtl/bhm_count_store.sv =====
// Count store: 256-entry count memory with valid bits, forwarding and saturating increment.
`timescale 1ns / 1ps

module bhm_count_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  bhm_pkg::t_byte  i_rd_addr,
    input  bhm_pkg::t_step  i_step,
    output bhm_pkg::t_count o_new_count
);
    import bhm_pkg::*;

    t_count                r_mem [NUM_VALUES];
    t_count                r_rd_data;
    logic [NUM_VALUES-1:0] r_vld;
    logic                  r_fwd_hit;
    t_count                r_fwd_count;
    t_count                cur_count;
    t_count                n_count;
    logic                  do_write;

    assign do_write = i_step.fire && (i_step.value != ZERO_BYTE);

    // Current count of the value in the update stage; the forward covers a
    // write that landed on the same edge as this entry's read
    always_comb begin
        if (!r_vld[i_step.value]) begin
            cur_count = '0;
        end else if (r_fwd_hit) begin
            cur_count = r_fwd_count;
        end else begin
            cur_count = r_rd_data;
        end
        n_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + t_count'(1);
    end

    assign o_new_count = n_count;

    // Memory read and write ports
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (do_write) begin
            r_mem[i_step.value] <= n_count;
        end
        if (i_rd_en) begin
            r_fwd_count <= n_count;
        end
    end

    // Forward flag: the request being read is the one just written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= do_write && !i_step.last && (i_step.value == i_rd_addr);
        end
    end

    // Valid bits: all cleared at reset and after each block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_step.fire && i_step.last) begin
            r_vld <= '0;
        end else if (do_write) begin
            r_vld[i_step.value] <= 1'b1;
        end
    end

endmodule : bhm_count_store

// ===== hw/rtl/bhm_mode_track.sv =====
// Mode tracker: running best count and value, plus the result register.
`timescale 1ns / 1ps

module bhm_mode_track (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bhm_pkg::t_step  i_step,
    input  bhm_pkg::t_count i_new_count,
    input  logic            i_ready,
    output logic            o_valid,
    output bhm_pkg::t_byte  o_most_common_byte
);
    import bhm_pkg::*;

    t_count r_best_count;
    t_byte  r_best_value;
    logic   r_out_valid;
    t_byte  r_out_value;
    logic   beat;
    t_count n_best_count;
    t_byte  n_best_value;

    // New record only when the updated count strictly exceeds the best
    always_comb begin
        beat = i_step.fire && (i_step.value != ZERO_BYTE) && (i_new_count > r_best_count);
        n_best_count = beat ? i_new_count : r_best_count;
        n_best_value = beat ? i_step.value : r_best_value;
    end

    // Record registers, cleared after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_count <= '0;
            r_best_value <= ZERO_BYTE;
        end else if (i_step.fire && i_step.last) begin
            r_best_count <= '0;
            r_best_value <= ZERO_BYTE;
        end else begin
            r_best_count <= n_best_count;
            r_best_value <= n_best_value;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step.fire && i_step.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.fire && i_step.last) begin
            r_out_value <= n_best_value;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_most_common_byte = r_out_value;

endmodule : bhm_mode_track

// ===== hw/rtl/byte_histogram_mode_finder.sv =====
// Byte histogram mode finder: top level with input stage and handshakes.
// Throughput: one byte per cycle, back to back, unless a last byte waits on an unread result.
// Path: the last byte goes through the input/read register, then the count update into the result
// register; it waits in the input stage while an earlier result is still unread.
// Reset clears the count valid bits, the record and both valid flags directly,
// with no clearing pass. The counts are cleared the same way after each result.
`timescale 1ns / 1ps

module byte_histogram_mode_finder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bhm_pkg::t_byte i_byte_value,
    input  logic           i_last_item,
    output logic           o_valid,
    input  logic           i_ready,
    output bhm_pkg::t_byte o_most_common_byte
);
    import bhm_pkg::*;

    logic   r_s1_valid;
    t_byte  r_s1_value;
    logic   r_s1_last;
    logic   in_fire;
    logic   s1_fire;
    t_step  step;
    t_count new_count;

    // The update stage stalls only when it would produce a result into a full register
    assign s1_fire = r_s1_valid && (!r_s1_last || !o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign in_fire = i_valid && o_ready;

    assign step.fire  = s1_fire;
    assign step.value = r_s1_value;
    assign step.last  = r_s1_last;

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_value <= i_byte_value;
            r_s1_last  <= i_last_item;
        end
    end

    bhm_count_store u_count_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_fire),
        .i_rd_addr   (i_byte_value),
        .i_step      (step),
        .o_new_count (new_count)
    );

    bhm_mode_track u_mode_track (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_new_count        (new_count),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_most_common_byte (o_most_common_byte)
    );

endmodule : byte_histogram_mode_finder
